### rtl/prz_pkg.sv
// ----------------------------------------------------------------------------
// prz_pkg: shared types and constants
// Constants, state encodings and helpers for the point rotate and height tagger.
// ----------------------------------------------------------------------------
`default_nettype none

package prz_pkg;

    localparam int MAX_FRAME_POINTS_DEF = 65536;
    localparam int REFLECTIVITY_DEF     = 100;

    localparam int COEF_W  = 18;
    localparam int ROW_W   = 54;
    localparam int CRD_W   = 32;
    localparam int TOTAL_W = 17;
    localparam int LINE_W  = 8;
    localparam int ACC_W   = 52;
    localparam int PROD_W  = COEF_W + CRD_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LINES    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NS      = 3'd7;

    localparam logic [ROW_W-1:0] ROT_ROW_X_RST = 54'd65536;
    localparam logic [ROW_W-1:0] ROT_ROW_Y_RST = 54'd65536 << 18;
    localparam logic [ROW_W-1:0] ROT_ROW_Z_RST = 54'd65536 << 36;
    localparam logic signed [CRD_W-1:0] MIN_HEIGHT_RST    = 32'sh8000_0000;
    localparam logic signed [CRD_W-1:0] MAX_HEIGHT_RST    = 32'sh7FFF_FFFF;
    localparam logic signed [CRD_W-1:0] HEIGHT_OFFSET_RST = 32'sd98304;
    localparam logic [LINE_W-1:0]       SCAN_LINES_RST    = 8'd4;
    localparam logic [31:0]             FRAME_NS_RST      = 32'd100000000;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAC,
        F_CLASS
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic signed [CRD_W-1:0] sat32(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-17:0] sh;
        sh = acc[ACC_W-1:16];
        if (sh > 36'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (sh < -36'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return sh[CRD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/prz_if.sv
// ----------------------------------------------------------------------------
// prz_if: point and result channels
// Valid/ready channels carrying one input point and one tagged result point.
// ----------------------------------------------------------------------------
`default_nettype none

interface prz_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        frame_points;
    logic               frame_end;

    modport source (output valid, px, py, pz, frame_points, frame_end, input ready);
    modport sink   (input valid, px, py, pz, frame_points, frame_end, output ready);
endinterface

interface prz_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic [7:0]         reflect_level;
    logic [7:0]         line_number;
    logic [31:0]        time_ofs;
    logic               frame_last;

    modport source (output valid, ox, oy, oz, reflect_level, line_number, time_ofs,
                    frame_last, input ready);
    modport sink   (input valid, ox, oy, oz, reflect_level, line_number, time_ofs,
                    frame_last, output ready);
endinterface

`default_nettype wire

### rtl/prz_fifo.sv
// ----------------------------------------------------------------------------
// prz_fifo: two-entry request queue
// Decouples the classifying front end from the timing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module prz_fifo
    import prz_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output      logic [W-1:0] o_data,
    output      t_q_stat      o_stat
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

### rtl/prz_front.sv
// ----------------------------------------------------------------------------
// prz_front: rotation and height band classification
// Rotates a point with one shared multiplier, filters on height and keeps count.
// ----------------------------------------------------------------------------
`default_nettype none

module prz_front
    import prz_pkg::*;
#(
    parameter int MAX_FRAME_POINTS = MAX_FRAME_POINTS_DEF,
    parameter int CW = $clog2(MAX_FRAME_POINTS + 1),
    parameter int JW = 3 * CRD_W + CW + TOTAL_W + 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    prz_in_if.sink                       i_pt,
    input  wire logic [ROW_W-1:0]        i_row_x,
    input  wire logic [ROW_W-1:0]        i_row_y,
    input  wire logic [ROW_W-1:0]        i_row_z,
    input  wire logic signed [CRD_W-1:0] i_min_height,
    input  wire logic signed [CRD_W-1:0] i_max_height,
    input  wire logic signed [CRD_W-1:0] i_height_offset,
    input  wire t_q_stat                 i_q_stat,
    output      logic                    o_push,
    output      logic [JW-1:0]           o_job
);

    t_front_state r_state, n_state;

    logic signed [CRD_W-1:0]  r_x, r_y, r_z;
    logic [TOTAL_W-1:0]       r_total;
    logic                     r_last;
    logic [3:0]               r_step;
    logic [1:0]               r_prow;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_x, r_acc_y, r_acc_z;
    logic [CW-1:0]            r_kept;

    logic [1:0]               w_row;
    logic [1:0]               w_col;
    logic [ROW_W-1:0]         w_row_bits;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [CRD_W-1:0]  w_crd;
    logic signed [CRD_W-1:0]  w_rx, w_ry, w_rz, w_oz;
    logic                     w_keep;
    logic                     w_accept;
    logic                     w_done;

    assign w_row = (r_step >= 4'd6) ? 2'd2 : ((r_step >= 4'd3) ? 2'd1 : 2'd0);
    assign w_col = 2'(r_step - 4'(3 * w_row));

    always_comb begin
        case (w_row)
            2'd0:    w_row_bits = i_row_x;
            2'd1:    w_row_bits = i_row_y;
            default: w_row_bits = i_row_z;
        endcase
        case (w_col)
            2'd0: begin
                w_coef = w_row_bits[17:0];
                w_crd  = r_x;
            end
            2'd1: begin
                w_coef = w_row_bits[35:18];
                w_crd  = r_y;
            end
            default: begin
                w_coef = w_row_bits[53:36];
                w_crd  = r_z;
            end
        endcase
    end

    assign w_rx   = sat32(r_acc_x);
    assign w_ry   = sat32(r_acc_y);
    assign w_rz   = sat32(r_acc_z);
    assign w_oz   = w_rz + i_height_offset;
    assign w_keep = (w_rz >= i_min_height) && (w_rz <= i_max_height);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_pt.valid) begin
                    n_state = F_MAC;
                end
            end
            F_MAC: begin
                if (r_step == 4'd9) begin
                    n_state = F_CLASS;
                end
            end
            F_CLASS: begin
                if (!w_keep || !i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        i_pt.ready = 1'b0;
        o_push     = 1'b0;
        w_done     = 1'b0;
        case (r_state)
            F_IDLE:  i_pt.ready = 1'b1;
            F_CLASS: begin
                o_push = w_keep && !i_q_stat.full;
                w_done = !w_keep || !i_q_stat.full;
            end
            default: begin
                i_pt.ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_pt.valid && i_pt.ready;
    assign o_job    = {w_rx, w_ry, w_oz, r_kept, r_total, r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_kept  <= '0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                if (r_last) begin
                    r_kept <= '0;
                end else if (w_keep && (r_kept < CW'(MAX_FRAME_POINTS))) begin
                    r_kept <= r_kept + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_pt.px;
            r_y     <= i_pt.py;
            r_z     <= i_pt.pz;
            r_total <= i_pt.frame_points;
            r_last  <= i_pt.frame_end;
            r_step  <= 4'd0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (r_state == F_MAC) begin
            if (r_step != 4'd9) begin
                r_prod <= w_coef * w_crd;
                r_prow <= w_row;
            end
            if (r_step != 4'd0) begin
                case (r_prow)
                    2'd0:    r_acc_x <= r_acc_x + ACC_W'(r_prod);
                    2'd1:    r_acc_y <= r_acc_y + ACC_W'(r_prod);
                    default: r_acc_z <= r_acc_z + ACC_W'(r_prod);
                endcase
            end
            r_step <= r_step + 4'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/prz_back.sv
// ----------------------------------------------------------------------------
// prz_back: line number and time offset
// Computes the time offset and line number with a two-bit-per-cycle divider.
// ----------------------------------------------------------------------------
`default_nettype none

module prz_back
    import prz_pkg::*;
#(
    parameter int MAX_FRAME_POINTS = MAX_FRAME_POINTS_DEF,
    parameter int REFLECTIVITY     = REFLECTIVITY_DEF,
    parameter int CW = $clog2(MAX_FRAME_POINTS + 1),
    parameter int JW = 3 * CRD_W + CW + TOTAL_W + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [LINE_W-1:0]  i_scan_lines,
    input  wire logic [31:0]        i_frame_ns,
    input  wire t_q_stat            i_q_stat,
    input  wire logic [JW-1:0]      i_job,
    output      logic               o_pop,
    prz_out_if.source               o_pt
);

    localparam int PW = 32 + CW;
    localparam int DW = PW + (PW % 2);
    localparam int NIT = DW / 2;
    localparam int IW = $clog2(NIT + 1);

    t_back_state r_state, n_state;

    logic signed [CRD_W-1:0] r_rx, r_ry, r_oz;
    logic [CW-1:0]           r_cnt;
    logic [TOTAL_W-1:0]      r_total;
    logic                    r_last;
    logic [DW-1:0]           r_dvd;
    logic [DW-1:0]           r_csh;
    logic [DW-1:0]           r_q;
    logic [TOTAL_W:0]        r_rem;
    logic [LINE_W:0]         r_mrem;
    logic [IW-1:0]           r_it;

    logic                    r_ovalid;
    logic signed [CRD_W-1:0] r_ox, r_oy, r_ozo;
    logic [LINE_W-1:0]       r_line;
    logic [31:0]             r_time;
    logic                    r_olast;

    logic [TOTAL_W:0]        w_rem;
    logic [LINE_W:0]         w_mrem;
    logic [1:0]              w_qb;
    logic                    w_load;
    logic [31:0]             w_time;
    logic [PW-1:0]           w_prod;

    always_comb begin
        w_rem  = r_rem;
        w_mrem = r_mrem;
        w_qb   = 2'b00;
        for (int k = 0; k < 2; k++) begin
            w_rem  = {w_rem[TOTAL_W-1:0], r_dvd[DW-1-k]};
            w_mrem = {w_mrem[LINE_W-1:0], r_csh[DW-1-k]};
            if (w_rem >= {1'b0, r_total}) begin
                w_rem    = w_rem - {1'b0, r_total};
                w_qb[1-k] = 1'b1;
            end
            if (w_mrem >= {1'b0, i_scan_lines}) begin
                w_mrem = w_mrem - {1'b0, i_scan_lines};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: n_state = B_DIV;
            B_DIV: begin
                if (r_it == IW'(NIT - 1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_ovalid || o_pt.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        case (r_state)
            B_IDLE: o_pop  = !i_q_stat.empty;
            B_DONE: w_load = !r_ovalid || o_pt.ready;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign w_prod = i_frame_ns * r_cnt;
    assign w_time = ((r_total == '0) || (|r_q[DW-1:32])) ? 32'hFFFF_FFFF : r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_pt.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                {r_rx, r_ry, r_oz, r_cnt, r_total, r_last} <= i_job;
            end
            B_MUL: begin
                r_dvd  <= DW'(w_prod);
                r_csh  <= DW'(r_cnt);
                r_q    <= '0;
                r_rem  <= '0;
                r_mrem <= '0;
                r_it   <= '0;
            end
            B_DIV: begin
                r_dvd  <= {r_dvd[DW-3:0], 2'b00};
                r_csh  <= {r_csh[DW-3:0], 2'b00};
                r_q    <= {r_q[DW-3:0], w_qb};
                r_rem  <= w_rem;
                r_mrem <= w_mrem;
                r_it   <= r_it + 1'b1;
            end
            default: begin
                if (w_load) begin
                    r_ox    <= r_rx;
                    r_oy    <= r_ry;
                    r_ozo   <= r_oz;
                    r_line  <= (i_scan_lines == '0) ? '0 : r_mrem[LINE_W-1:0];
                    r_time  <= w_time;
                    r_olast <= r_last;
                end
            end
        endcase
    end

    assign o_pt.valid         = r_ovalid;
    assign o_pt.ox            = r_ox;
    assign o_pt.oy            = r_oy;
    assign o_pt.oz            = r_ozo;
    assign o_pt.reflect_level = LINE_W'(REFLECTIVITY);
    assign o_pt.line_number   = r_line;
    assign o_pt.time_ofs      = r_time;
    assign o_pt.frame_last    = r_olast;

endmodule

`default_nettype wire

### rtl/point_rotate_zband_tagger_top.sv
// ----------------------------------------------------------------------------
// point_rotate_zband_tagger_top: point rotation and height band tagger
// Rotates points, drops those outside the height band and tags kept ones.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Payload
// i_pt      in   valid/ready    px, py, pz, frame_points, frame_end
// o_pt      out  valid/ready    ox, oy, oz, reflect_level, line_number,
//                               time_ofs, frame_last
// cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
// The front end rotates each point with nine passes through one 18x32
// multiplier and takes a new point only once the last one is classified.
// The back end tags each kept point with the two-bit-per-cycle divider.
// A two-entry queue lets each side stall on its own. Reset is synchronous
// and restores the register defaults and clears the kept count.
`default_nettype none

module point_rotate_zband_tagger_top
    import prz_pkg::*;
#(
    parameter int MAX_FRAME_POINTS = MAX_FRAME_POINTS_DEF,
    parameter int REFLECTIVITY     = REFLECTIVITY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    prz_in_if.sink                    i_pt,
    prz_out_if.source                 o_pt,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ROW_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_FRAME_POINTS + 1);
    localparam int JW = 3 * CRD_W + CW + TOTAL_W + 1;

    logic [ROW_W-1:0]        r_row_x, r_row_y, r_row_z;
    logic signed [CRD_W-1:0] r_min_height, r_max_height, r_height_offset;
    logic [LINE_W-1:0]       r_scan_lines;
    logic [31:0]             r_frame_ns;

    logic          w_push;
    logic          w_pop;
    logic [JW-1:0] w_job_in;
    logic [JW-1:0] w_job_out;
    t_q_stat       w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x         <= ROT_ROW_X_RST;
            r_row_y         <= ROT_ROW_Y_RST;
            r_row_z         <= ROT_ROW_Z_RST;
            r_min_height    <= MIN_HEIGHT_RST;
            r_max_height    <= MAX_HEIGHT_RST;
            r_height_offset <= HEIGHT_OFFSET_RST;
            r_scan_lines    <= SCAN_LINES_RST;
            r_frame_ns      <= FRAME_NS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROT_ROW_X:     r_row_x         <= i_cfg_data;
                CFG_ROT_ROW_Y:     r_row_y         <= i_cfg_data;
                CFG_ROT_ROW_Z:     r_row_z         <= i_cfg_data;
                CFG_MIN_HEIGHT:    r_min_height    <= i_cfg_data[31:0];
                CFG_MAX_HEIGHT:    r_max_height    <= i_cfg_data[31:0];
                CFG_HEIGHT_OFFSET: r_height_offset <= i_cfg_data[31:0];
                CFG_SCAN_LINES:    r_scan_lines    <= i_cfg_data[7:0];
                CFG_FRAME_NS:      r_frame_ns      <= i_cfg_data[31:0];
                default: begin
                    r_frame_ns <= r_frame_ns;
                end
            endcase
        end
    end

    prz_front #(
        .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
        .CW               (CW),
        .JW               (JW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pt            (i_pt),
        .i_row_x         (r_row_x),
        .i_row_y         (r_row_y),
        .i_row_z         (r_row_z),
        .i_min_height    (r_min_height),
        .i_max_height    (r_max_height),
        .i_height_offset (r_height_offset),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_job           (w_job_in)
    );

    prz_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_q_stat)
    );

    prz_back #(
        .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
        .REFLECTIVITY     (REFLECTIVITY),
        .CW               (CW),
        .JW               (JW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan_lines (r_scan_lines),
        .i_frame_ns   (r_frame_ns),
        .i_q_stat     (w_q_stat),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_pt         (o_pt)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("request queue read while empty");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && (r_scan_lines != '0)) |-> (o_pt.line_number < r_scan_lines))
        else $error("line number outside scan line range");

endmodule

`default_nettype wire

### sim/prz_tb_if.sv
// ----------------------------------------------------------------------------
// prz_tb_if: testbench view of the point channels
// The point and result channels are the interfaces from the RTL; this file
// only holds the record of one expected result shared by the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prz_tb_pkg;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic [7:0]         reflect_level;
        logic [7:0]         line_number;
        logic [31:0]        time_ofs;
        logic               frame_last;
    } t_tagged_point;

endpackage

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: point rotation and height band tagger
// Drives points through the block under random idling and stalls, and
// compares every tagged point with a behavioral predictor of the rotation,
// the height band and the per-frame tagging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import prz_pkg::*;
    import prz_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ROW_W-1:0] i_cfg_data = '0;

    prz_in_if  pt_in ();
    prz_out_if pt_out ();

    point_rotate_zband_tagger_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pt(pt_in.sink), .o_pt(pt_out.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    logic [53:0] row_x, row_y, row_z;
    logic signed [31:0] band_lo, band_hi, z_lift;
    logic [7:0] line_count;
    logic [31:0] frame_len_ns;
    int unsigned kept_in_frame;

    t_tagged_point pending_points[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;

    function automatic logic signed [31:0] rotate_row(input logic [53:0] row,
            input logic signed [31:0] x, input logic signed [31:0] y,
            input logic signed [31:0] z);
        logic signed [63:0] acc;
        logic signed [63:0] sh;
        acc = $signed(row[17:0]) * 64'(x) + $signed(row[35:18]) * 64'(y)
            + $signed(row[53:36]) * 64'(z);
        sh = acc >>> 16;
        if (sh > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (sh < -64'sd2147483648) return 32'sh8000_0000;
        return sh[31:0];
    endfunction

    task automatic predict_tagging(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic signed [31:0] z, input logic [16:0] total, input logic last);
        t_tagged_point p;
        logic [63:0] t;
        p.ox = rotate_row(row_x, x, y, z);
        p.oy = rotate_row(row_y, x, y, z);
        p.oz = rotate_row(row_z, x, y, z);
        if (p.oz >= band_lo && p.oz <= band_hi) begin
            p.oz = p.oz + z_lift;
            p.reflect_level = 8'd100;
            p.line_number = (line_count == 0) ? 8'd0 : 8'(kept_in_frame % line_count);
            if (total == 0) begin
                t = 64'hFFFF_FFFF;
            end else begin
                t = (64'(frame_len_ns) * 64'(kept_in_frame)) / 64'(total);
                if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            end
            p.time_ofs = t[31:0];
            p.frame_last = last;
            pending_points = {pending_points, p};
            if (kept_in_frame < 65536) kept_in_frame++;
        end
        if (last) kept_in_frame = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [53:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROT_ROW_X: row_x = val;
            CFG_ROT_ROW_Y: row_y = val;
            CFG_ROT_ROW_Z: row_z = val;
            CFG_MIN_HEIGHT: band_lo = val[31:0];
            CFG_MAX_HEIGHT: band_hi = val[31:0];
            CFG_HEIGHT_OFFSET: z_lift = val[31:0];
            CFG_SCAN_LINES: line_count = val[7:0];
            CFG_FRAME_NS: frame_len_ns = val[31:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        pt_in.valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // A request stays on the bus until taken; the predictor runs at acceptance.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic signed [31:0] z, input logic [16:0] total, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.px <= x;
        pt_in.py <= y;
        pt_in.pz <= z;
        pt_in.frame_points <= total;
        pt_in.frame_end <= last;
        @(posedge i_clk);
        while (!pt_in.ready) @(posedge i_clk);
        predict_tagging(x, y, z, total, last);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            pt_out.ready <= 1'b0;
        end else begin
            pt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tagged_point want;
        t_tagged_point got;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            got = '{pt_out.ox, pt_out.oy, pt_out.oz, pt_out.reflect_level,
                    pt_out.line_number, pt_out.time_ofs, pt_out.frame_last};
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected point %p", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", want, got);
                end
            end
        end
    end

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [16:0] total;
        logic last;
        logic kept;
        logic signed [31:0] want_oz;
        logic [31:0] want_time;
    } t_point_row;

    // Under the reset matrix: pass-through, z lifted by 1.5 m.
    t_point_row reset_rows[] = '{
        '{32'sd0, 32'sd0, 32'sd0, 17'd4, 1'b0, 1'b1, 32'sd98304, 32'd0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 17'd4, 1'b0, 1'b1,
          32'sh8001_7FFF, 32'd25000000},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 17'd0, 1'b0, 1'b1,
          32'sh8001_8000, 32'hFFFF_FFFF},
        '{32'sd1, -32'sd1, 32'sd65536, 17'd1, 1'b1, 1'b1, 32'sd163840, 32'd300000000},
        '{32'sd5, 32'sd6, 32'sd7, 17'h1FFFF, 1'b1, 1'b1, 32'sd98311, 32'd0}
    };

    function automatic logic [53:0] rand_row(input int mode);
        logic [17:0] c[3];
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0: c[k] = 18'($urandom);
                1: c[k] = 18'($signed($urandom_range(131072)) - 65536);
                default: c[k] = $urandom_range(1) ? 18'h1FFFF : 18'h20000;
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
        endcase
    endfunction

    task automatic random_frames(input int count);
        int sent;
        int frame_len;
        int seen;
        logic [16:0] total;
        sent = 0;
        while (sent < count) begin
            frame_len = $urandom_range(1, 12);
            total = ($urandom_range(9) == 0) ? 17'($urandom) : 17'(frame_len);
            seen = 0;
            while (seen < frame_len && sent < count) begin
                seen++;
                sent++;
                send_point(rand_coord(), rand_coord(), rand_coord(), total,
                           seen == frame_len || $urandom_range(30) == 0);
            end
        end
    endtask

    initial begin
        t_tagged_point p;
        pt_in.valid = 1'b0;
        pt_in.px = '0;
        pt_in.py = '0;
        pt_in.pz = '0;
        pt_in.frame_points = '0;
        pt_in.frame_end = 1'b0;
        pt_out.ready = 1'b0;
        row_x = ROT_ROW_X_RST;
        row_y = ROT_ROW_Y_RST;
        row_z = ROT_ROW_Z_RST;
        band_lo = MIN_HEIGHT_RST;
        band_hi = MAX_HEIGHT_RST;
        z_lift = HEIGHT_OFFSET_RST;
        line_count = SCAN_LINES_RST;
        frame_len_ns = FRAME_NS_RST;
        kept_in_frame = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (reset_rows[r]) begin
            send_point(reset_rows[r].x, reset_rows[r].y, reset_rows[r].z,
                       reset_rows[r].total, reset_rows[r].last);
            p = pending_points[pending_points.size() - 1];
            if (!reset_rows[r].kept || p.oz !== reset_rows[r].want_oz
                    || p.time_ofs !== reset_rows[r].want_time) begin
                mismatches++;
                if (mismatches <= 10) $display("table row %0d predicted %p", r, p);
            end
        end
        wait_drained();

        // Inverted band drops all; dropped last point still clears the count.
        write_reg(CFG_MIN_HEIGHT, 54'(32'sd100));
        write_reg(CFG_MAX_HEIGHT, 54'(32'sd0));
        write_reg(CFG_SCAN_LINES, 54'd0);
        write_reg(CFG_FRAME_NS, 54'hFFFF_FFFF);
        send_point(32'sd10, 32'sd20, 32'sd50, 17'd3, 1'b0);
        send_point(32'sd10, 32'sd20, 32'sd50, 17'd3, 1'b1);
        wait_drained();
        write_reg(CFG_MIN_HEIGHT, 54'(-32'sd65536));
        write_reg(CFG_MAX_HEIGHT, 54'(32'sd65536));
        write_reg(CFG_HEIGHT_OFFSET, 54'(32'sh7FFF_FFFF));
        send_point(32'sd100, 32'sd1, 32'sd65536, 17'd2, 1'b0);
        send_point(32'sd100, 32'sd1, 32'sd65537, 17'd2, 1'b0);
        send_point(32'sd100, 32'sd1, -32'sd65536, 17'd1, 1'b0);
        send_point(32'sd3, 32'sd4, 32'sd0, 17'd1, 1'b1);
        wait_drained();
        write_reg(CFG_ROT_ROW_X, {18'h20000, 18'h20000, 18'h20000});
        write_reg(CFG_ROT_ROW_Y, {18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
        write_reg(CFG_ROT_ROW_Z, {18'h00000, 18'h00001, 18'h3FFFF});
        write_reg(CFG_MIN_HEIGHT, 54'(32'sh8000_0000));
        write_reg(CFG_MAX_HEIGHT, 54'(32'sh7FFF_FFFF));
        write_reg(CFG_SCAN_LINES, 54'd255);
        for (int k = 0; k < 6; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 17'd6, k == 5);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(CFG_ROT_ROW_X, rand_row(phase % 3));
            write_reg(CFG_ROT_ROW_Y, rand_row((phase + 1) % 3));
            write_reg(CFG_ROT_ROW_Z, (phase == 0) ? ROT_ROW_Z_RST : rand_row(1));
            write_reg(CFG_MIN_HEIGHT, 54'(-32'($urandom_range(1 << 24))));
            write_reg(CFG_MAX_HEIGHT, 54'(32'($urandom_range(1 << 24))));
            write_reg(CFG_HEIGHT_OFFSET, 54'($urandom));
            write_reg(CFG_SCAN_LINES, 54'($urandom_range(255)));
            write_reg(CFG_FRAME_NS, 54'($urandom));
            if (phase == 2) hold_off_cycles = 400;
            random_frames(112);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
